// ----- hw/rtl/oal_pkg.sv -----
`default_nettype none

package oal_pkg;

    // Default list depth in entries
    localparam int DEPTH_DEF = 16;

    // Field widths fixed by the interface
    localparam int OP_W    = 3;
    localparam int VAL_W   = 32;
    localparam int CNT_W   = 5;
    localparam int ST_W    = 3;
    localparam int FOUND_W = 4;

    // Capacity after reset
    localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

    // Opcodes
    localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
    localparam logic [OP_W-1:0] OP_POP    = 3'd3;
    localparam logic [OP_W-1:0] OP_SEARCH = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [ST_W-1:0] ST_BADPOS   = 3'd3;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;

    // Command transaction
    typedef struct packed {
        logic [OP_W-1:0]         opcode;
        logic signed [VAL_W-1:0] value;
        logic [CNT_W-1:0]        position;
    } in_t;

    // Result transaction
    typedef struct packed {
        logic [ST_W-1:0]    status;
        logic [FOUND_W-1:0] found_position;
        logic [CNT_W-1:0]   entry_count;
        logic               full_flag;
        logic               empty_flag;
    } out_t;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INS_RD,
        S_INS_WR,
        S_INS_PUT,
        S_REM_RD,
        S_REM_WR,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/oal_ram.sv -----
`default_nettype none

module oal_ram #(
    parameter int DEPTH = oal_pkg::DEPTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]      wr_addr,
    input  wire logic [oal_pkg::VAL_W-1:0]     wr_data,
    input  wire logic                          rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]      rd_addr,
    output logic      [oal_pkg::VAL_W-1:0]     rd_data
);

    logic [oal_pkg::VAL_W-1:0] mem [DEPTH];
    logic [oal_pkg::VAL_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/oal_ctrl.sv -----
`default_nettype none

module oal_ctrl #(
    parameter int DEPTH = oal_pkg::DEPTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // effective capacity; the user must keep it stable except while idle, unchecked here
    input  wire logic [oal_pkg::CNT_W-1:0]     cap_eff,
    // command side
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire oal_pkg::in_t                  in_data,
    // result side
    input  wire logic                          out_free,
    output logic                               done,
    output oal_pkg::out_t                      result,
    // entry memory
    output logic                               wr_en,
    output logic [$clog2(DEPTH)-1:0]           wr_addr,
    output logic [oal_pkg::VAL_W-1:0]          wr_data,
    output logic                               rd_en,
    output logic [$clog2(DEPTH)-1:0]           rd_addr,
    input  wire logic [oal_pkg::VAL_W-1:0]     rd_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = oal_pkg::CNT_W;
    localparam int FW = oal_pkg::FOUND_W;

    oal_pkg::state_t state_reg, state_next;

    logic [oal_pkg::OP_W-1:0]  op_reg;
    logic [oal_pkg::VAL_W-1:0] val_reg;
    logic [CW-1:0]             pos_reg;
    logic [CW-1:0]             idx_reg, idx_next;
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic [oal_pkg::ST_W-1:0]  status_reg, status_next;
    logic [FW-1:0]             found_reg, found_next;

    // Shared index stepper and compare unit
    logic          step_up;
    logic [CW-1:0] idx_step;
    logic [CW-1:0] cnt_inc;
    logic [CW-1:0] cnt_dec;
    logic          is_full;
    logic          list_empty;
    logic          ins_bad;
    logic          rem_bad;
    logic          match;

    assign step_up  = (state_reg == oal_pkg::S_REM_RD)  || (state_reg == oal_pkg::S_REM_WR) ||
                      (state_reg == oal_pkg::S_SRCH_RD) || (state_reg == oal_pkg::S_SRCH_CMP);
    assign idx_step = idx_reg + (step_up ? CW'(1) : {CW{1'b1}});
    assign cnt_inc  = cnt_reg + CW'(1);
    assign cnt_dec  = cnt_reg - CW'(1);
    assign is_full  = (cnt_reg >= cap_eff);
    assign list_empty = (cnt_reg == '0);
    assign ins_bad  = (pos_reg > cnt_reg);
    assign rem_bad  = (pos_reg >= cnt_reg);
    assign match    = (rd_data == val_reg);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            oal_pkg::S_IDLE: begin
                if (in_valid) begin
                    state_next = oal_pkg::S_DECODE;
                end
            end
            oal_pkg::S_DECODE: begin
                state_next = oal_pkg::S_DONE;
                case (op_reg)
                    oal_pkg::OP_INSERT: begin
                        if (!is_full && !ins_bad) begin
                            state_next = (cnt_reg == pos_reg) ? oal_pkg::S_INS_PUT
                                                              : oal_pkg::S_INS_RD;
                        end
                    end
                    oal_pkg::OP_REMOVE: begin
                        if (!list_empty && !rem_bad && (pos_reg != cnt_dec)) begin
                            state_next = oal_pkg::S_REM_RD;
                        end
                    end
                    oal_pkg::OP_SEARCH: begin
                        if (!list_empty) begin
                            state_next = oal_pkg::S_SRCH_RD;
                        end
                    end
                    default: begin
                        state_next = oal_pkg::S_DONE;
                    end
                endcase
            end
            oal_pkg::S_INS_RD: begin
                state_next = oal_pkg::S_INS_WR;
            end
            oal_pkg::S_INS_WR: begin
                state_next = (idx_step == pos_reg) ? oal_pkg::S_INS_PUT : oal_pkg::S_INS_RD;
            end
            oal_pkg::S_INS_PUT: begin
                state_next = oal_pkg::S_DONE;
            end
            oal_pkg::S_REM_RD: begin
                state_next = oal_pkg::S_REM_WR;
            end
            oal_pkg::S_REM_WR: begin
                state_next = (idx_step == cnt_dec) ? oal_pkg::S_DONE : oal_pkg::S_REM_RD;
            end
            oal_pkg::S_SRCH_RD: begin
                state_next = oal_pkg::S_SRCH_CMP;
            end
            oal_pkg::S_SRCH_CMP: begin
                state_next = (match || (idx_step == cnt_reg)) ? oal_pkg::S_DONE
                                                              : oal_pkg::S_SRCH_RD;
            end
            oal_pkg::S_DONE: begin
                if (out_free) begin
                    state_next = oal_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = oal_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath next values
    always_comb begin
        idx_next    = idx_reg;
        cnt_next    = cnt_reg;
        status_next = status_reg;
        found_next  = found_reg;
        case (state_reg)
            oal_pkg::S_IDLE: begin
                status_next = oal_pkg::ST_OK;
                found_next  = '0;
            end
            oal_pkg::S_DECODE: begin
                case (op_reg)
                    oal_pkg::OP_APPEND: begin
                        if (is_full) begin
                            status_next = oal_pkg::ST_FULL;
                        end else begin
                            cnt_next = cnt_inc;
                        end
                    end
                    oal_pkg::OP_INSERT: begin
                        if (is_full) begin
                            status_next = oal_pkg::ST_FULL;
                        end else if (ins_bad) begin
                            status_next = oal_pkg::ST_BADPOS;
                        end else begin
                            idx_next = cnt_reg;
                        end
                    end
                    oal_pkg::OP_REMOVE: begin
                        if (list_empty) begin
                            status_next = oal_pkg::ST_EMPTY;
                        end else if (rem_bad) begin
                            status_next = oal_pkg::ST_BADPOS;
                        end else begin
                            idx_next = pos_reg;
                            // removing the last entry needs no shift
                            if (pos_reg == cnt_dec) begin
                                cnt_next = cnt_dec;
                            end
                        end
                    end
                    oal_pkg::OP_POP: begin
                        if (list_empty) begin
                            status_next = oal_pkg::ST_EMPTY;
                        end else begin
                            cnt_next = cnt_dec;
                        end
                    end
                    oal_pkg::OP_SEARCH: begin
                        if (list_empty) begin
                            status_next = oal_pkg::ST_NOTFOUND;
                        end else begin
                            idx_next = '0;
                        end
                    end
                    oal_pkg::OP_CLEAR: begin
                        cnt_next = '0;
                    end
                    default: begin
                        cnt_next = cnt_reg;
                    end
                endcase
            end
            oal_pkg::S_INS_WR: begin
                idx_next = idx_step;
            end
            oal_pkg::S_INS_PUT: begin
                cnt_next = cnt_inc;
            end
            oal_pkg::S_REM_WR: begin
                idx_next = idx_step;
                if (idx_step == cnt_dec) begin
                    cnt_next = cnt_dec;
                end
            end
            oal_pkg::S_SRCH_CMP: begin
                idx_next = idx_step;
                if (match) begin
                    found_next = idx_reg[FW-1:0];
                end else if (idx_step == cnt_reg) begin
                    status_next = oal_pkg::ST_NOTFOUND;
                end
            end
            default: begin
                idx_next = idx_reg;
            end
        endcase
    end

    // Outputs: handshake and memory port
    always_comb begin
        in_ready = (state_reg == oal_pkg::S_IDLE);
        done     = (state_reg == oal_pkg::S_DONE);
        wr_en    = 1'b0;
        wr_addr  = AW'(idx_reg);
        wr_data  = rd_data;
        rd_en    = 1'b0;
        rd_addr  = AW'(idx_step);
        unique case (state_reg)
            oal_pkg::S_DECODE: begin
                if ((op_reg == oal_pkg::OP_APPEND) && !is_full) begin
                    wr_en   = 1'b1;
                    wr_addr = AW'(cnt_reg);
                    wr_data = val_reg;
                end
            end
            oal_pkg::S_INS_RD, oal_pkg::S_REM_RD: begin
                rd_en = 1'b1;
            end
            oal_pkg::S_INS_WR, oal_pkg::S_REM_WR: begin
                wr_en = 1'b1;
            end
            oal_pkg::S_INS_PUT: begin
                wr_en   = 1'b1;
                wr_addr = AW'(pos_reg);
                wr_data = val_reg;
            end
            oal_pkg::S_SRCH_RD: begin
                rd_en   = 1'b1;
                rd_addr = AW'(idx_reg);
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Result of the finished command
    always_comb begin
        result.status         = status_reg;
        result.found_position = found_reg;
        result.entry_count    = cnt_reg;
        result.full_flag      = is_full;
        result.empty_flag     = list_empty;
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= oal_pkg::S_IDLE;
            cnt_reg    <= '0;
            idx_reg    <= '0;
            status_reg <= oal_pkg::ST_OK;
            found_reg  <= '0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            idx_reg    <= idx_next;
            status_reg <= status_next;
            found_reg  <= found_next;
        end
    end

    // Command capture
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            op_reg  <= in_data.opcode;
            val_reg <= in_data.value;
            pos_reg <= in_data.position;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ordered_array_list_engine.sv -----
`default_nettype none

// Ordered list of signed 32-bit entries with append, insert, remove, pop,
// search and clear commands.
// Commands arrive on the s_ channel (valid/ready) and each gives exactly
// one result on the m_ channel (valid/ready), in command order.
// One command is worked at a time; s_ready is low until its result has
// moved into the output register. A single index stepper walks the entry
// memory, whose read data is registered, so each entry moved or compared
// takes a read state and then a write or compare state:
//   append, pop, clear, no-op, rejected commands: decode, then the result
//   insert: decode, a read and a write per entry above the position, then the put
//   remove: decode, a read and a write per entry above the position
//   search: decode, a read and a compare per entry until a match or the end
// The result register frees the engine: a new command may be taken while
// a result waits; if m_ready stays low the next result holds in the engine.
// cfg_wr_en writes the capacity register at once; write it only while no
// command is in flight.
// Reset (aresetn low, synchronous) empties the list and sets capacity to 16.
module ordered_array_list_engine #(
    parameter int DEPTH = oal_pkg::DEPTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [oal_pkg::CNT_W-1:0]     cfg_wr_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire oal_pkg::in_t                  s_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output oal_pkg::out_t                      m_data
);

    localparam int AW      = $clog2(DEPTH);
    localparam int CW      = oal_pkg::CNT_W;
    localparam int CAP_MAX = (DEPTH > 31) ? 31 : DEPTH;

    logic [CW-1:0]              capacity_reg;
    logic [CW-1:0]              cap_eff;
    logic                       m_valid_reg;
    oal_pkg::out_t              m_data_reg;
    logic                       out_free;
    logic                       done;
    oal_pkg::out_t              result;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [oal_pkg::VAL_W-1:0]  wr_data;
    logic                       rd_en;
    logic [AW-1:0]              rd_addr;
    logic [oal_pkg::VAL_W-1:0]  rd_data;

    // Capacity register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= oal_pkg::CAP_RESET;
        end else if (cfg_wr_en) begin
            capacity_reg <= cfg_wr_data;
        end
    end

    // Capacity saturates at the memory depth or 31, whichever is less
    assign cap_eff = (capacity_reg > CW'(CAP_MAX)) ? CW'(CAP_MAX) : capacity_reg;

    // Output register
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= done;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && done) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    oal_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cap_eff  (cap_eff),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_data  (s_data),
        .out_free (out_free),
        .done     (done),
        .result   (result),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data)
    );

    oal_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

`default_nettype wire

// ----- bench/tb_ordered_array_list_engine.sv -----
`timescale 1ns / 1ps

module tb_ordered_array_list_engine;
    import oal_pkg::*;

    // Predicts each result from its own copy of the list and holds the
    // expected results in command order.
    class list_scoreboard;
        logic [VAL_W-1:0] shadow [DEPTH_DEF];
        int unsigned      used;
        logic [CNT_W-1:0] cap_reg;
        out_t             expected_q [$];
        int               errors;

        function new();
            foreach (shadow[i]) shadow[i] = '0;
            used    = 0;
            cap_reg = CAP_RESET;
            errors  = 0;
        endfunction

        // Capacity above the depth saturates
        function int unsigned eff_cap();
            return (cap_reg > DEPTH_DEF) ? DEPTH_DEF : int'(cap_reg);
        endfunction

        function void set_capacity(logic [CNT_W-1:0] v);
            cap_reg = v;
        endfunction

        function int unsigned count_now();
            return used;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Work out the result of one accepted command transaction
        function void note_command(in_t c);
            out_t        e;
            int unsigned cap;
            int unsigned pos;
            logic [ST_W-1:0] st;
            int unsigned hit_at;
            bit          hit;
            cap    = eff_cap();
            pos    = c.position;
            st     = ST_OK;
            hit_at = 0;
            hit    = 1'b0;
            case (c.opcode)
                OP_APPEND: begin
                    if (used >= cap) begin
                        st = ST_FULL;
                    end else begin
                        shadow[used] = c.value;
                        used++;
                    end
                end
                OP_INSERT: begin
                    // full check wins over the position check
                    if (used >= cap) begin
                        st = ST_FULL;
                    end else if (pos > used) begin
                        st = ST_BADPOS;
                    end else begin
                        for (int i = used; i > pos; i--) shadow[i] = shadow[i-1];
                        shadow[pos] = c.value;
                        used++;
                    end
                end
                OP_REMOVE: begin
                    if (used == 0) begin
                        st = ST_EMPTY;
                    end else if (pos >= used) begin
                        st = ST_BADPOS;
                    end else begin
                        for (int i = pos; i + 1 < used; i++) shadow[i] = shadow[i+1];
                        used--;
                    end
                end
                OP_POP: begin
                    if (used == 0) st = ST_EMPTY;
                    else used--;
                end
                OP_SEARCH: begin
                    st = ST_NOTFOUND;
                    for (int i = 0; i < used; i++) begin
                        if (!hit && shadow[i] == c.value) begin
                            hit    = 1'b1;
                            hit_at = i;
                        end
                    end
                    if (hit) st = ST_OK;
                end
                OP_CLEAR: begin
                    used = 0;
                end
                default: begin
                    // unused opcodes do nothing
                end
            endcase
            e.status         = st;
            e.found_position = hit_at[FOUND_W-1:0];
            e.entry_count    = used[CNT_W-1:0];
            e.full_flag      = (used >= cap);
            e.empty_flag     = (used == 0);
            expected_q.push_back(e);
        endfunction

        task report_mismatch(string what, int got, int want);
            $display("%0t ns: mismatch on %s: got %0d, expected %0d", $realtime, what, got,
                     want);
            errors++;
        endtask

        // Compare one result transaction with the oldest expectation
        task check_result(out_t r);
            out_t e;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result, status", r.status, -1);
            end else begin
                e = expected_q.pop_front();
                if (r.status !== e.status)
                    report_mismatch("status", r.status, e.status);
                if (r.found_position !== e.found_position)
                    report_mismatch("found_position", r.found_position, e.found_position);
                if (r.entry_count !== e.entry_count)
                    report_mismatch("entry_count", r.entry_count, e.entry_count);
                if (r.full_flag !== e.full_flag)
                    report_mismatch("full_flag", r.full_flag, e.full_flag);
                if (r.empty_flag !== e.empty_flag)
                    report_mismatch("empty_flag", r.empty_flag, e.empty_flag);
            end
        endtask
    endclass

    logic             aclk        = 1'b0;
    logic             aresetn     = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [CNT_W-1:0] cfg_wr_data = '0;
    logic             s_valid     = 1'b0;
    logic             s_ready;
    in_t              s_data      = '0;
    logic             m_valid;
    logic             m_ready     = 1'b0;
    out_t             m_data;

    int send_idle = 0;
    int recv_idle = 0;

    list_scoreboard sb = new();

    ordered_array_list_engine #(
        .DEPTH(DEPTH_DEF)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Receiver back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    // Watch both channels
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_command(s_data);
            if (m_valid && m_ready) sb.check_result(m_data);
        end
    end

    function automatic in_t make_cmd(logic [OP_W-1:0] op, logic [VAL_W-1:0] v,
                                     logic [CNT_W-1:0] pos);
        in_t c;
        c.opcode   = op;
        c.value    = v;
        c.position = pos;
        return c;
    endfunction

    // Offer one command transaction, with random gaps before it
    task automatic send_cmd(input in_t c);
        while ($urandom_range(0, 99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Stop sending until every expected result is back
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() > 0) @(posedge aclk);
    endtask

    // Capacity is written only with the engine idle
    task automatic write_capacity(input logic [CNT_W-1:0] v);
        wait_drained();
        repeat (40) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_capacity(v);
    endtask

    // Random commands: growth-biased so the list often reaches full
    task automatic run_chunk(input int n);
        int               k;
        int               r;
        logic [OP_W-1:0]  op;
        logic [VAL_W-1:0] v;
        logic [CNT_W-1:0] pos;
        for (k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 30)      op = OP_APPEND;
            else if (r < 50) op = OP_INSERT;
            else if (r < 62) op = OP_REMOVE;
            else if (r < 70) op = OP_POP;
            else if (r < 91) op = OP_SEARCH;
            else if (r < 94) op = OP_CLEAR;
            else             op = OP_W'(OP_CLEAR + 1 + $urandom_range(0, 1));
            // small pool so searches hit, plus full-range values
            if ($urandom_range(0, 99) < 60) v = int'($urandom_range(0, 7)) - 4;
            else                            v = $urandom;
            if ($urandom_range(0, 99) < 80) pos = CNT_W'($urandom_range(0, sb.count_now() + 1));
            else                            pos = CNT_W'($urandom_range(0, 31));
            send_cmd(make_cmd(op, v, pos));
            if (k == n / 2) wait_drained();
        end
    endtask

    // Main sequence
    initial begin
        logic [CNT_W-1:0] caps [9];
        int               ph;
        int               j;
        caps = '{5'd16, 5'd31, 5'd0, 5'd3, 5'd17, 5'd1, 5'd8, 5'd12, 5'd16};

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty list corners
        send_cmd(make_cmd(OP_SEARCH, 32'd0, 5'd0));
        send_cmd(make_cmd(OP_POP, 32'd0, 5'd0));
        send_cmd(make_cmd(OP_REMOVE, 32'd0, 5'd0));
        // Value extremes, insert at end and front, bad positions
        send_cmd(make_cmd(OP_APPEND, 32'h8000_0000, 5'd0));
        send_cmd(make_cmd(OP_APPEND, 32'h7fff_ffff, 5'd0));
        send_cmd(make_cmd(OP_INSERT, 32'hffff_ffff, 5'd2));
        send_cmd(make_cmd(OP_INSERT, 32'd0, 5'd0));
        send_cmd(make_cmd(OP_INSERT, 32'd9, 5'd31));
        send_cmd(make_cmd(OP_INSERT, 32'd9, 5'd5));
        send_cmd(make_cmd(OP_SEARCH, 32'h7fff_ffff, 5'd0));
        send_cmd(make_cmd(OP_SEARCH, 32'd12345, 5'd0));
        send_cmd(make_cmd(OP_REMOVE, 32'd0, 5'd4));
        send_cmd(make_cmd(OP_REMOVE, 32'd0, 5'd1));
        send_cmd(make_cmd(OP_POP, 32'd0, 5'd0));
        send_cmd(make_cmd(OP_CLEAR + 3'd1, $urandom, 5'd31));
        send_cmd(make_cmd(OP_CLEAR + 3'd2, $urandom, 5'd0));
        send_cmd(make_cmd(OP_CLEAR, 32'd0, 5'd0));
        send_cmd(make_cmd(OP_SEARCH, 32'h8000_0000, 5'd0));

        // Zero capacity: append and insert both full
        write_capacity(5'd0);
        send_cmd(make_cmd(OP_APPEND, 32'd1, 5'd0));
        send_cmd(make_cmd(OP_INSERT, 32'd1, 5'd7));

        // Fill to two, then lower capacity below the count
        write_capacity(5'd2);
        send_cmd(make_cmd(OP_APPEND, 32'd5, 5'd0));
        send_cmd(make_cmd(OP_APPEND, 32'd6, 5'd0));
        send_cmd(make_cmd(OP_APPEND, 32'd7, 5'd0));
        write_capacity(5'd1);
        send_cmd(make_cmd(OP_INSERT, 32'd8, 5'd0));
        send_cmd(make_cmd(OP_SEARCH, 32'd6, 5'd0));
        send_cmd(make_cmd(OP_REMOVE, 32'd0, 5'd0));

        // Random phases with three idling profiles
        for (ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_idle = 20;
                    recv_idle = 57;
                end
                1: begin
                    send_idle = 57;
                    recv_idle = 20;
                end
                default: begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            for (j = 0; j < 3; j++) begin
                write_capacity(caps[ph * 3 + j]);
                run_chunk(138);
            end
        end

        wait_drained();
        repeat (40) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- ordered_array_list_engine.f -----
hw/rtl/oal_pkg.sv
hw/rtl/oal_ram.sv
hw/rtl/oal_ctrl.sv
hw/rtl/ordered_array_list_engine.sv
bench/tb_ordered_array_list_engine.sv
